// ===== design/ps2mct_pkg.sv =====
// Shared types, codes and helpers for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

	// Item kinds on the input channel
	typedef enum logic [1:0] {
		FUNC_PS2  = 2'd0,
		FUNC_REL  = 2'd1,
		FUNC_ABS  = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	// Decoded commands passed from the front end to the executor
	typedef enum logic [1:0] {
		CMD_NOP  = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_ABS  = 2'd2,
		CMD_READ = 2'd3
	} cmd_kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PENDING = 2'd1,
		ST_SYNC    = 2'd2,
		ST_OVF     = 2'd3
	} status_t;

	// Register indexes (byte address bit 2)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int BOUND_W = 13;
	localparam int POS_W   = 12;
	localparam int PROD_W  = 28;

	localparam logic [BOUND_W-1:0] WIDTH_RST  = 13'd1024;
	localparam logic [BOUND_W-1:0] HEIGHT_RST = 13'd768;
	localparam int CURSOR_X_RST = 512;
	localparam int CURSOR_Y_RST = 384;

	// PS/2 header bits
	localparam logic [7:0] SYNC_MASK  = 8'h08;
	localparam logic [7:0] XSIGN_MASK = 8'h10;
	localparam logic [7:0] YSIGN_MASK = 8'h20;
	localparam logic [7:0] OVF_MASK   = 8'hC0;
	localparam logic [7:0] BTN_MASK   = 8'h07;

	// Full scale of absolute positions
	localparam logic [15:0] ABS_FULL = 16'd32767;

	// Decode queue
	localparam int QUEUE_DEPTH = 4;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [BOUND_W-1:0] w;
		logic [BOUND_W-1:0] h;
		logic [BOUND_W-1:0] w_m1;
		logic [BOUND_W-1:0] h_m1;
	} bounds_t;

	typedef struct packed {
		cmd_kind_t          kind;
		status_t            status;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [7:0]         buttons;
		logic [BOUND_W-1:0] nx;
		logic [BOUND_W-1:0] ny;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	// Usable bound: zero acts as one, capped at the coordinate range
	function automatic logic [BOUND_W-1:0] eff_bound(input logic [BOUND_W-1:0] r,
		input logic [16:0] cap);
		logic [BOUND_W-1:0] res;
		if (r == '0) begin
			res = BOUND_W'(1);
		end else if ({4'b0, r} > cap) begin
			res = cap[BOUND_W-1:0];
		end else begin
			res = r;
		end
		return res;
	endfunction

	// p / 32767 for p < 2^28: estimate with a shift, one correction step
	function automatic logic [BOUND_W-1:0] div_full(input logic [PROD_W-1:0] p);
		logic [BOUND_W-1:0] q0;
		logic [15:0]        rem;
		logic [BOUND_W-1:0] q;
		q0  = p[PROD_W-1:15];
		rem = {1'b0, p[14:0]} + {3'b0, q0};
		q   = (rem >= ABS_FULL) ? q0 + BOUND_W'(1) : q0;
		return q;
	endfunction

endpackage

// ===== design/ps2mct_regs.sv =====
// Configuration registers (screen bounds) behind the APB-style port.
module ps2mct_regs #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output ps2mct_pkg::bounds_t   bounds
);

	localparam logic [16:0] CAP = 17'(1) << COORD_BITS;

	logic [ps2mct_pkg::BOUND_W-1:0] width_q;
	logic [ps2mct_pkg::BOUND_W-1:0] height_q;
	logic [ps2mct_pkg::BOUND_W-1:0] eff_w;
	logic [ps2mct_pkg::BOUND_W-1:0] eff_h;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	assign eff_w = ps2mct_pkg::eff_bound(pwdata[ps2mct_pkg::BOUND_W-1:0], CAP);
	assign eff_h = eff_w;

	// Raw registers plus the usable bounds derived at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= ps2mct_pkg::WIDTH_RST;
			height_q    <= ps2mct_pkg::HEIGHT_RST;
			bounds.w    <= ps2mct_pkg::eff_bound(ps2mct_pkg::WIDTH_RST, CAP);
			bounds.h    <= ps2mct_pkg::eff_bound(ps2mct_pkg::HEIGHT_RST, CAP);
			bounds.w_m1 <= ps2mct_pkg::eff_bound(ps2mct_pkg::WIDTH_RST, CAP)
				- ps2mct_pkg::BOUND_W'(1);
			bounds.h_m1 <= ps2mct_pkg::eff_bound(ps2mct_pkg::HEIGHT_RST, CAP)
				- ps2mct_pkg::BOUND_W'(1);
		end else if (wr_en) begin
			case (paddr[2])
				ps2mct_pkg::REG_WIDTH: begin
					width_q     <= pwdata[ps2mct_pkg::BOUND_W-1:0];
					bounds.w    <= eff_w;
					bounds.w_m1 <= eff_w - ps2mct_pkg::BOUND_W'(1);
				end
				ps2mct_pkg::REG_HEIGHT: begin
					height_q    <= pwdata[ps2mct_pkg::BOUND_W-1:0];
					bounds.h    <= eff_h;
					bounds.h_m1 <= eff_h - ps2mct_pkg::BOUND_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			ps2mct_pkg::REG_WIDTH:  prdata = {19'b0, width_q};
			ps2mct_pkg::REG_HEIGHT: prdata = {19'b0, height_q};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== design/ps2mct_fifo.sv =====
// Small register queue between the decode front end and the executor.
module ps2mct_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CW'(DEPTH))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

// ===== design/ps2mct_front.sv =====
// Front end: accepts items, assembles PS/2 packets, scales absolute positions.
module ps2mct_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic [7:0]                   data_byte,
	input  logic signed [15:0]           delta_x,
	input  logic signed [15:0]           delta_y,
	input  logic [14:0]                  abs_x,
	input  logic [14:0]                  abs_y,
	input  logic [7:0]                   buttons_in,
	input  ps2mct_pkg::bounds_t          bounds,
	input  logic [ps2mct_pkg::CNT_W-1:0] queue_count,
	output logic                         push,
	output ps2mct_pkg::cmd_t             push_cmd
);

	typedef enum logic [1:0] {
		PKT_HEAD,
		PKT_XMOVE,
		PKT_YMOVE
	} pkt_state_t;

	pkt_state_t pkt_q, pkt_d;
	logic [7:0] hdr_q, hdr_d;
	logic [7:0] xm_q, xm_d;

	logic                               s1_valid_q;
	ps2mct_pkg::cmd_kind_t              kind_s1, kind_d;
	ps2mct_pkg::status_t                status_s1, status_d;
	logic signed [15:0]                 dx_s1, dx_d;
	logic signed [15:0]                 dy_s1, dy_d;
	logic [7:0]                         btn_s1, btn_d;
	logic [ps2mct_pkg::PROD_W-1:0]      px_s1;
	logic [ps2mct_pkg::PROD_W-1:0]      py_s1;

	logic               accept;
	logic [8:0]         xv9;
	logic [8:0]         yv9;
	logic signed [15:0] yv16;

	// Credit check: queue entries plus the item in stage 1
	assign in_stall = ({1'b0, queue_count} + (ps2mct_pkg::CNT_W + 1)'(s1_valid_q))
		>= (ps2mct_pkg::CNT_W + 1)'(ps2mct_pkg::QUEUE_DEPTH);
	assign accept = in_valid & ~in_stall;

	// Packet moves, 9-bit two's complement
	assign xv9  = {(|(hdr_q & ps2mct_pkg::XSIGN_MASK)), xm_q};
	assign yv9  = {(|(hdr_q & ps2mct_pkg::YSIGN_MASK)), data_byte};
	assign yv16 = {{7{yv9[8]}}, yv9};

	// Classify the item
	always_comb begin
		pkt_d    = pkt_q;
		hdr_d    = hdr_q;
		xm_d     = xm_q;
		kind_d   = ps2mct_pkg::CMD_NOP;
		status_d = ps2mct_pkg::ST_OK;
		dx_d     = delta_x;
		dy_d     = delta_y;
		btn_d    = buttons_in;
		case (ps2mct_pkg::func_t'(func))
			ps2mct_pkg::FUNC_PS2: begin
				case (pkt_q)
					PKT_HEAD: begin
						if ((data_byte & ps2mct_pkg::SYNC_MASK) == '0) begin
							status_d = ps2mct_pkg::ST_SYNC;
						end else begin
							hdr_d    = data_byte;
							pkt_d    = PKT_XMOVE;
							status_d = ps2mct_pkg::ST_PENDING;
						end
					end
					PKT_XMOVE: begin
						xm_d     = data_byte;
						pkt_d    = PKT_YMOVE;
						status_d = ps2mct_pkg::ST_PENDING;
					end
					PKT_YMOVE: begin
						pkt_d = PKT_HEAD;
						if ((hdr_q & ps2mct_pkg::OVF_MASK) != '0) begin
							status_d = ps2mct_pkg::ST_OVF;
						end else begin
							kind_d = ps2mct_pkg::CMD_MOVE;
							dx_d   = {{7{xv9[8]}}, xv9};
							dy_d   = -yv16;
							btn_d  = hdr_q & ps2mct_pkg::BTN_MASK;
						end
					end
					default: pkt_d = PKT_HEAD;
				endcase
			end
			ps2mct_pkg::FUNC_REL:  kind_d = ps2mct_pkg::CMD_MOVE;
			ps2mct_pkg::FUNC_ABS:  kind_d = ps2mct_pkg::CMD_ABS;
			ps2mct_pkg::FUNC_READ: kind_d = ps2mct_pkg::CMD_READ;
			default:               kind_d = ps2mct_pkg::CMD_NOP;
		endcase
	end

	// Packet state and stage 1 register (scaling products taken here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q      <= PKT_HEAD;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (accept) begin
				pkt_q     <= pkt_d;
				hdr_q     <= hdr_d;
				xm_q      <= xm_d;
				kind_s1   <= kind_d;
				status_s1 <= status_d;
				dx_s1     <= dx_d;
				dy_s1     <= dy_d;
				btn_s1    <= btn_d;
				px_s1     <= abs_x * bounds.w_m1;
				py_s1     <= abs_y * bounds.h_m1;
			end
		end
	end

	// Finish the scaling and hand the command to the queue
	assign push = s1_valid_q;
	always_comb begin
		push_cmd.kind    = kind_s1;
		push_cmd.status  = status_s1;
		push_cmd.dx      = dx_s1;
		push_cmd.dy      = dy_s1;
		push_cmd.buttons = btn_s1;
		push_cmd.nx      = ps2mct_pkg::div_full(px_s1);
		push_cmd.ny      = ps2mct_pkg::div_full(py_s1);
	end

endmodule

// ===== design/ps2mct_back.sv =====
// Executor: applies commands to the cursor state and holds the result register.
module ps2mct_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ps2mct_pkg::bounds_t          bounds,
	input  ps2mct_pkg::queue_head_t      head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [11:0]                  pos_x,
	output logic [11:0]                  pos_y,
	output logic [7:0]                   buttons_out,
	output logic                         moved,
	output logic                         clicked,
	output logic [1:0]                   event_status
);

	// Cursor storage: holds the reset position and any in-bound value
	localparam int CUR_W = (COORD_BITS < 10) ? 10 :
		((COORD_BITS > ps2mct_pkg::BOUND_W) ? ps2mct_pkg::BOUND_W : COORD_BITS);
	localparam int SUM_W = 18;
	localparam int BW    = ps2mct_pkg::BOUND_W;

	logic [CUR_W-1:0] cursor_x_q, cx_d;
	logic [CUR_W-1:0] cursor_y_q, cy_d;
	logic [7:0]       button_q, btn_d;
	logic             moved_q, mv_d;
	logic             clicked_q, ck_d;
	logic             out_valid_q;

	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	ps2mct_pkg::cmd_t        c;

	function automatic logic [BW-1:0] clamp(input logic signed [SUM_W-1:0] v,
		input logic [BW-1:0] b);
		logic [BW-1:0] res;
		if (v[SUM_W-1]) begin
			res = '0;
		end else if (v[SUM_W-2:0] >= (SUM_W-1)'(b)) begin
			res = b - BW'(1);
		end else begin
			res = v[BW-1:0];
		end
		return res;
	endfunction

	assign c   = head.cmd;
	assign pop = head.valid & (~out_valid_q | ~out_stall);

	assign sum_x = $signed({{(SUM_W-CUR_W){1'b0}}, cursor_x_q})
		+ $signed({{(SUM_W-16){c.dx[15]}}, c.dx});
	assign sum_y = $signed({{(SUM_W-CUR_W){1'b0}}, cursor_y_q})
		+ $signed({{(SUM_W-16){c.dy[15]}}, c.dy});

	// Next state for the command at the queue head
	always_comb begin
		cx_d  = cursor_x_q;
		cy_d  = cursor_y_q;
		btn_d = button_q;
		mv_d  = moved_q;
		ck_d  = clicked_q;
		case (c.kind)
			ps2mct_pkg::CMD_MOVE: begin
				cx_d  = CUR_W'(clamp(sum_x, bounds.w));
				cy_d  = CUR_W'(clamp(sum_y, bounds.h));
				mv_d  = moved_q | (c.dx != '0) | (c.dy != '0);
				ck_d  = clicked_q | (c.buttons != button_q);
				btn_d = c.buttons;
			end
			ps2mct_pkg::CMD_ABS: begin
				cx_d  = CUR_W'(c.nx);
				cy_d  = CUR_W'(c.ny);
				mv_d  = moved_q | (c.nx != BW'(cursor_x_q)) | (c.ny != BW'(cursor_y_q));
				ck_d  = clicked_q | (c.buttons != button_q);
				btn_d = c.buttons;
			end
			default: ;
		endcase
	end

	// State update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= CUR_W'(ps2mct_pkg::CURSOR_X_RST);
			cursor_y_q  <= CUR_W'(ps2mct_pkg::CURSOR_Y_RST);
			button_q    <= '0;
			moved_q     <= 1'b0;
			clicked_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				cursor_x_q   <= cx_d;
				cursor_y_q   <= cy_d;
				button_q     <= btn_d;
				moved_q      <= (c.kind == ps2mct_pkg::CMD_READ) ? 1'b0 : mv_d;
				clicked_q    <= (c.kind == ps2mct_pkg::CMD_READ) ? 1'b0 : ck_d;
				pos_x        <= ps2mct_pkg::POS_W'(cx_d);
				pos_y        <= ps2mct_pkg::POS_W'(cy_d);
				buttons_out  <= btn_d;
				moved        <= mv_d;
				clicked      <= ck_d;
				event_status <= c.status;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_move_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		pop && c.kind == ps2mct_pkg::CMD_MOVE |=>
			BW'(cursor_x_q) < $past(bounds.w) && BW'(cursor_y_q) < $past(bounds.h))
		else $error("cursor outside bounds after move");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && c.kind == ps2mct_pkg::CMD_READ |=> !moved_q && !clicked_q)
		else $error("read did not clear sticky flags");

	a_hold_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !pop)
		else $error("executor popped while result held");

endmodule

// ===== design/ps2_mouse_cursor_tracker_core.sv =====
// PS/2 mouse cursor tracker: top level.
//
// Input channel (in_valid / in_stall) takes one item per cycle while in_stall
// is low: func selects a PS/2 byte, a relative move, an absolute position or a
// read that clears the sticky moved and clicked flags. Every item yields
// exactly one result on the output channel (out_valid / out_stall) with the
// cursor, buttons, flags and an event status.
// Each accepted item is decoded and its scaling products taken in stage 1,
// then it is written to the queue, then the executor loads the result register.
// Throughput is one item per cycle when neither channel stalls.
// When out_stall is high the result register holds; the four-entry queue
// keeps taking items until it and stage 1 together hold four items, then
// in_stall rises.
// Reset clears the queue and the packet assembler, puts the cursor at 512,384
// with buttons and flags clear, and sets bounds 1024 by 768. Bounds, written
// at 0x0 (width) and 0x4 (height) of the APB port, do not re-clamp the cursor;
// the user must write them only while no item is in flight (not enforced).
module ps2_mouse_cursor_tracker_core #(
	parameter int COORD_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         data_byte,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [14:0]        abs_x,
	input  logic [14:0]        abs_y,
	input  logic [7:0]         buttons_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        pos_x,
	output logic [11:0]        pos_y,
	output logic [7:0]         buttons_out,
	output logic               moved,
	output logic               clicked,
	output logic [1:0]         event_status
);

	localparam int CMD_W = $bits(ps2mct_pkg::cmd_t);

	ps2mct_pkg::bounds_t          bounds;
	logic                         push;
	ps2mct_pkg::cmd_t             push_cmd;
	logic                         pop;
	logic [CMD_W-1:0]             q_rdata;
	logic                         q_empty;
	logic [ps2mct_pkg::CNT_W-1:0] q_count;
	ps2mct_pkg::queue_head_t      head;

	ps2mct_regs #(
		.COORD_BITS(COORD_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bounds  (bounds)
	);

	ps2mct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.data_byte   (data_byte),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.abs_x       (abs_x),
		.abs_y       (abs_y),
		.buttons_in  (buttons_in),
		.bounds      (bounds),
		.queue_count (q_count),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	ps2mct_fifo #(
		.W     (CMD_W),
		.DEPTH (ps2mct_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	assign head.valid = ~q_empty;
	assign head.cmd   = ps2mct_pkg::cmd_t'(q_rdata);

	ps2mct_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bounds       (bounds),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.buttons_out  (buttons_out),
		.moved        (moved),
		.clicked      (clicked),
		.event_status (event_status)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse cursor tracker core.
module testbench;

	localparam int COORD_BITS  = 12;
	localparam int BOUND_CAP   = 1 << COORD_BITS;
	localparam int ABS_SCALE   = 32767;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES      = 8;
	localparam int RAND_ITEMS  = 135;

	typedef struct packed {
		ps2mct_pkg::func_t fn;
		logic [7:0]        data;
		logic [15:0]       dx;
		logic [15:0]       dy;
		logic [14:0]       ax;
		logic [14:0]       ay;
		logic [7:0]        btn;
	} mouse_item_t;

	typedef struct packed {
		logic [11:0]         x;
		logic [11:0]         y;
		logic [7:0]          btn;
		logic                moved;
		logic                clicked;
		ps2mct_pkg::status_t st;
	} cursor_report_t;

	// Ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic [7:0]         data_byte = '0;
	logic signed [15:0] delta_x = '0;
	logic signed [15:0] delta_y = '0;
	logic [14:0]        abs_x = '0;
	logic [14:0]        abs_y = '0;
	logic [7:0]         buttons_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [11:0]        pos_x;
	logic [11:0]        pos_y;
	logic [7:0]         buttons_out;
	logic               moved;
	logic               clicked;
	logic [1:0]         event_status;

	// Stimulus and scoreboard
	mouse_item_t    mouse_items_q[$];
	cursor_report_t cursor_reports_q[$];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             items_queued = 0;
	int             items_taken = 0;
	int             errors = 0;
	int             quiet_cycles = 0;
	logic           in_fire = 1'b0;

	// Mirror of the bound registers and the tracker state
	logic [12:0] width_reg = ps2mct_pkg::WIDTH_RST;
	logic [12:0] height_reg = ps2mct_pkg::HEIGHT_RST;
	logic [11:0] cur_x = 12'(ps2mct_pkg::CURSOR_X_RST);
	logic [11:0] cur_y = 12'(ps2mct_pkg::CURSOR_Y_RST);
	logic [7:0]  cur_btn = '0;
	logic        moved_sticky = 1'b0;
	logic        clicked_sticky = 1'b0;
	logic [1:0]  pkt_pos = '0;
	logic [7:0]  pkt_hdr = '0;
	logic [7:0]  pkt_xb = '0;

	ps2_mouse_cursor_tracker_core #(.COORD_BITS(COORD_BITS)) DUT (.*);

	always #5 clk = ~clk;

	// Zero acts as one, anything past the coordinate range is capped
	function automatic int usable_bound(input logic [12:0] r);
		if (r == '0) return 1;
		if (int'(r) > BOUND_CAP) return BOUND_CAP;
		return int'(r);
	endfunction

	function automatic logic [11:0] clamp_coord(input int v, input int bound);
		if (v < 0) return '0;
		if (v >= bound) return 12'(bound - 1);
		return 12'(v);
	endfunction

	task automatic shift_cursor(input int dx, input int dy);
		cur_x = clamp_coord(int'(cur_x) + dx, usable_bound(width_reg));
		cur_y = clamp_coord(int'(cur_y) + dy, usable_bound(height_reg));
		// moved sticks even when the clamp eats the whole move
		if (dx != 0 || dy != 0) moved_sticky = 1'b1;
	endtask

	task automatic update_buttons(input logic [7:0] b);
		if (b != cur_btn) clicked_sticky = 1'b1;
		cur_btn = b;
	endtask

	// Expected report for one accepted item; advances the mirrored state
	task automatic track_cursor(input mouse_item_t it, output cursor_report_t rep);
		logic signed [8:0] mx, my;
		int w, h, nx, ny;
		ps2mct_pkg::status_t st;
		st = ps2mct_pkg::ST_OK;
		w = usable_bound(width_reg);
		h = usable_bound(height_reg);
		case (it.fn)
		ps2mct_pkg::FUNC_PS2: begin
			if (pkt_pos == 2'd0) begin
				if ((it.data & ps2mct_pkg::SYNC_MASK) == '0) begin
					st = ps2mct_pkg::ST_SYNC;
				end else begin
					pkt_hdr = it.data;
					pkt_pos = 2'd1;
					st = ps2mct_pkg::ST_PENDING;
				end
			end else if (pkt_pos == 2'd1) begin
				pkt_xb = it.data;
				pkt_pos = 2'd2;
				st = ps2mct_pkg::ST_PENDING;
			end else begin
				pkt_pos = 2'd0;
				if ((pkt_hdr & ps2mct_pkg::OVF_MASK) != '0) begin
					st = ps2mct_pkg::ST_OVF;
				end else begin
					// 9-bit moves, PS/2 y grows upward
					mx = {(pkt_hdr & ps2mct_pkg::XSIGN_MASK) != '0, pkt_xb};
					my = {(pkt_hdr & ps2mct_pkg::YSIGN_MASK) != '0, it.data};
					shift_cursor(int'(mx), -int'(my));
					update_buttons(pkt_hdr & ps2mct_pkg::BTN_MASK);
				end
			end
		end
		ps2mct_pkg::FUNC_REL: begin
			shift_cursor(int'($signed(it.dx)), int'($signed(it.dy)));
			update_buttons(it.btn);
		end
		ps2mct_pkg::FUNC_ABS: begin
			nx = int'(it.ax) * (w - 1) / ABS_SCALE;
			ny = int'(it.ay) * (h - 1) / ABS_SCALE;
			if (nx >= w) nx = w - 1;
			if (ny >= h) ny = h - 1;
			if (nx != int'(cur_x) || ny != int'(cur_y)) moved_sticky = 1'b1;
			cur_x = 12'(nx);
			cur_y = 12'(ny);
			update_buttons(it.btn);
		end
		default: ;
		endcase
		rep.x = cur_x;
		rep.y = cur_y;
		rep.btn = cur_btn;
		rep.moved = moved_sticky;
		rep.clicked = clicked_sticky;
		rep.st = st;
		// a read reports the flags, then clears them
		if (it.fn == ps2mct_pkg::FUNC_READ) begin
			moved_sticky = 1'b0;
			clicked_sticky = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Queue one item; fields the kind does not use stay random
	task automatic post(input ps2mct_pkg::func_t fn, input logic [15:0] a,
		input logic [15:0] b, input logic [7:0] btn);
		mouse_item_t it;
		it.fn = fn;
		it.data = 8'($urandom);
		it.dx = 16'($urandom);
		it.dy = 16'($urandom);
		it.ax = 15'($urandom);
		it.ay = 15'($urandom);
		it.btn = 8'($urandom);
		case (fn)
		ps2mct_pkg::FUNC_PS2: it.data = a[7:0];
		ps2mct_pkg::FUNC_REL: begin
			it.dx = a;
			it.dy = b;
			it.btn = btn;
		end
		ps2mct_pkg::FUNC_ABS: begin
			it.ax = a[14:0];
			it.ay = b[14:0];
			it.btn = btn;
		end
		default: ;
		endcase
		mouse_items_q.push_back(it);
		items_queued++;
	endtask

	// Mostly well-formed packets and events, some noise and cut packets
	task automatic queue_random(input int count);
		int target, pick, dx, dy;
		logic [7:0] hdr, btn;
		target = items_queued + count;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			btn = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
			if (pick < 40) begin
				hdr = 8'($urandom) | ps2mct_pkg::SYNC_MASK;
				if ($urandom_range(99) < 85) hdr = hdr & ~ps2mct_pkg::OVF_MASK;
				post(ps2mct_pkg::FUNC_PS2, 16'(hdr), 0, 0);
				post(ps2mct_pkg::FUNC_PS2, 16'($urandom), 0, 0);
				if ($urandom_range(9) != 0) post(ps2mct_pkg::FUNC_PS2, 16'($urandom), 0, 0);
			end else if (pick < 50) begin
				post(ps2mct_pkg::FUNC_PS2, 16'($urandom), 0, 0);
			end else if (pick < 70) begin
				if ($urandom_range(4) == 0) begin
					dx = $urandom;
					dy = $urandom;
				end else begin
					dx = $urandom_range(300) - 150;
					dy = $urandom_range(300) - 150;
				end
				post(ps2mct_pkg::FUNC_REL, 16'(dx), 16'(dy), btn);
			end else if (pick < 85) begin
				post(ps2mct_pkg::FUNC_ABS, 16'($urandom), 16'($urandom), btn);
			end else begin
				post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
			end
		end
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_bound(input logic reg_sel, input logic [12:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == ps2mct_pkg::REG_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	task automatic drain();
		while (items_taken != items_queued || cursor_reports_q.size() != 0) @(negedge clk);
	endtask

	// Driver: new item or idle at the falling edge, random stall on results
	always @(negedge clk) begin : drive_ports
		mouse_item_t it;
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (mouse_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = mouse_items_q.pop_front();
					func <= it.fn;
					data_byte <= it.data;
					delta_x <= it.dx;
					delta_y <= it.dy;
					abs_x <= it.ax;
					abs_y <= it.ay;
					buttons_in <= it.btn;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: predict on accepted items, compare accepted results
	always @(posedge clk) begin : watch_ports
		mouse_item_t it;
		cursor_report_t want;
		logic out_fire;
		in_fire = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (in_fire) begin
			it.fn = ps2mct_pkg::func_t'(func);
			it.data = data_byte;
			it.dx = delta_x;
			it.dy = delta_y;
			it.ax = abs_x;
			it.ay = abs_y;
			it.btn = buttons_in;
			track_cursor(it, want);
			cursor_reports_q.push_back(want);
			items_taken++;
		end
		if (out_fire) begin
			if (cursor_reports_q.size() == 0) begin
				$error("result with no item pending: pos_x %0d pos_y %0d", pos_x, pos_y);
				errors++;
			end else begin
				want = cursor_reports_q.pop_front();
				check_field("pos_x", want.x, pos_x);
				check_field("pos_y", want.y, pos_y);
				check_field("buttons_out", want.btn, buttons_out);
				check_field("moved", want.moved, moved);
				check_field("clicked", want.clicked, clicked);
				check_field("event_status", want.st, event_status);
			end
		end
		// watchdog on cycles with no traffic
		quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Phases: directed items, then random items; each phase after the first sets new bounds
	initial begin : run_phases
		logic [12:0] widths[PHASES];
		logic [12:0] heights[PHASES];
		widths = '{13'd1024, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640, 13'd1, 13'd2};
		heights = '{13'd768, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd480, 13'd1, 13'd3};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed, reset bounds 1024 x 768
		post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'h00, 0, 0);      // first byte without sync bit
		post(ps2mct_pkg::FUNC_PS2, 16'h19, 0, 0);      // x negative, left button
		post(ps2mct_pkg::FUNC_PS2, 16'h00, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'hFF, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'hC8, 0, 0);      // both overflow bits: dropped
		post(ps2mct_pkg::FUNC_PS2, 16'h12, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'h34, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'h2F, 0, 0);      // y negative, all buttons
		post(ps2mct_pkg::FUNC_PS2, 16'hFF, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'h00, 0, 0);
		post(ps2mct_pkg::FUNC_REL, 16'h7FFF, 16'h7FFF, 8'hFF);
		post(ps2mct_pkg::FUNC_REL, 16'h8000, 16'h8000, 8'h00);
		post(ps2mct_pkg::FUNC_REL, 16'h0000, 16'h0000, 8'h00);
		post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
		post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
		post(ps2mct_pkg::FUNC_REL, 16'hFFFB, 16'hFFFB, 8'h00); // pinned at the corner
		post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
		post(ps2mct_pkg::FUNC_ABS, 16'h7FFF, 16'h7FFF, 8'hAA);
		post(ps2mct_pkg::FUNC_ABS, 16'h0000, 16'h0000, 8'hAA);
		post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
		post(ps2mct_pkg::FUNC_ABS, 16'h0000, 16'h0000, 8'hAA); // same spot: not moved
		post(ps2mct_pkg::FUNC_PS2, 16'h08, 0, 0);      // packet split by a relative move
		post(ps2mct_pkg::FUNC_REL, 16'd3, 16'hFFFD, 8'h55);
		post(ps2mct_pkg::FUNC_PS2, 16'h01, 0, 0);
		post(ps2mct_pkg::FUNC_PS2, 16'h02, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph != 0) begin
				if (ph == 6) begin
					widths[ph] = 13'($urandom_range(4096, 1));
					heights[ph] = 13'($urandom_range(4096, 1));
				end
				write_bound(ps2mct_pkg::REG_WIDTH, widths[ph]);
				write_bound(ps2mct_pkg::REG_HEIGHT, heights[ph]);
			end
			case (ph % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 54; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 54; end
			default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			// stored cursor shows through until the next move re-clamps it
			post(ps2mct_pkg::FUNC_READ, 0, 0, 0);
			queue_random(RAND_ITEMS);
		end

		drain();
		repeat (10) @(negedge clk);
		if (errors == 0 && cursor_reports_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
